>>> src/qpsl_pkg.sv
// Package for the quaternion pitch slew limiter: widths, constants, codes and the arctangent table.
`default_nettype none
package qpsl_pkg;

  localparam int unsigned QW      = 16;
  localparam int unsigned PW      = 16;
  localparam int unsigned PRODW   = 2 * QW;
  localparam int unsigned CW      = 38;
  localparam int unsigned ZW      = 21;
  localparam int unsigned THR_W   = 15;
  localparam int unsigned STEP_W  = 12;
  localparam int unsigned CFG_W   = 15;
  localparam int unsigned DIFF_W  = PW + 1;
  localparam int unsigned NEXT_W  = PW + 2;
  localparam int unsigned TAB_LEN = 24;
  localparam int unsigned TAB_W   = $clog2(TAB_LEN);
  localparam int unsigned RND_SH  = 4;

  localparam int unsigned CORDIC_ITER_DEF = 14;

  localparam logic [THR_W-1:0]  THR_RESET  = 15'd410;
  localparam logic [STEP_W-1:0] STEP_RESET = 12'd41;

  localparam logic signed [ZW-1:0] PI_Q16      = 21'sd205887;
  localparam logic signed [ZW-1:0] HALF_PI_Q16 = 21'sd102944;
  localparam logic signed [ZW-1:0] RND_BIAS    = 21'sd8;
  localparam logic signed [PW-1:0] PITCH_MIN   = -16'sd19303;
  localparam logic signed [PW-1:0] PITCH_MAX   = 16'sd6434;

  typedef enum logic [0:0] {
    REG_JUMP_THRESHOLD = 1'b0,
    REG_SLEW_STEP      = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_PREP,
    ST_ROT,
    ST_ROUND,
    ST_SLEW
  } state_e;

  typedef enum logic [2:0] {
    MUL_WW,
    MUL_XX,
    MUL_YY,
    MUL_ZZ,
    MUL_YZ,
    MUL_WX,
    MUL_END
  } mul_op_e;

  function automatic logic signed [ZW-1:0] atan_q16(input logic [TAB_W-1:0] idx);
    logic signed [ZW-1:0] r;
    unique case (idx)
      5'd0:    r = 21'sd51472;
      5'd1:    r = 21'sd30386;
      5'd2:    r = 21'sd16055;
      5'd3:    r = 21'sd8150;
      5'd4:    r = 21'sd4091;
      5'd5:    r = 21'sd2047;
      5'd6:    r = 21'sd1024;
      5'd7:    r = 21'sd512;
      5'd8:    r = 21'sd256;
      5'd9:    r = 21'sd128;
      5'd10:   r = 21'sd64;
      5'd11:   r = 21'sd32;
      5'd12:   r = 21'sd16;
      5'd13:   r = 21'sd8;
      5'd14:   r = 21'sd4;
      5'd15:   r = 21'sd2;
      5'd16:   r = 21'sd1;
      default: r = 21'sd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

>>> src/quaternion_pitch_slew_limiter.sv
// Top level: quaternion to pitch by shared multiplier and iterative CORDIC, then slew limit.
`default_nettype none
// A request is taken only while the block is idle; it then uses one shared
// 16x16 multiplier to build num and den, does a quadrant setup step, and runs
// CORDIC_ITERATIONS iterations on one shared shift-add CORDIC stage (a zero vector
// skips CORDIC), then a rounding step and a slew step; the next request can be taken
// once the block is idle again. The result sits
// in an output register; a new request is accepted while it waits, and the slew cycle
// holds until the output register is free. The pitch is Q3.12 radians in
// [-3pi/2, pi/2]; both configuration registers may be written any time the block is idle.
module quaternion_pitch_slew_limiter #(
  parameter int unsigned CORDIC_ITERATIONS = qpsl_pkg::CORDIC_ITER_DEF
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               cfg_we_i,
  input  wire  qpsl_pkg::cfg_reg_e          cfg_index_i,
  input  wire  [qpsl_pkg::CFG_W-1:0]        cfg_data_i,
  input  wire                               in_valid_i,
  output logic                              in_ready_o,
  input  wire  signed [qpsl_pkg::QW-1:0]    quat_w_i,
  input  wire  signed [qpsl_pkg::QW-1:0]    quat_x_i,
  input  wire  signed [qpsl_pkg::QW-1:0]    quat_y_i,
  input  wire  signed [qpsl_pkg::QW-1:0]    quat_z_i,
  output logic                              out_valid_o,
  input  wire                               out_ready_i,
  output logic signed [qpsl_pkg::PW-1:0]    pitch_angle_o
);
  import qpsl_pkg::*;

  localparam int unsigned IterW = (CORDIC_ITERATIONS > 1) ? $clog2(CORDIC_ITERATIONS) : 1;
  localparam logic [IterW-1:0] IterLast = IterW'(CORDIC_ITERATIONS - 1);

  state_e                   state_q, state_d;
  mul_op_e                  mop_q, mop_d;
  logic [IterW-1:0]         iter_q, iter_d;
  logic [THR_W-1:0]         thr_q, thr_d;
  logic [STEP_W-1:0]        step_q, step_d;
  logic signed [PW-1:0]     held_q, held_d;
  logic                     out_valid_q, out_valid_d;

  logic signed [QW-1:0]     qw_q, qx_q, qy_q, qz_q, qw_d, qx_d, qy_d, qz_d;
  logic signed [PRODW-1:0]  prod_q, prod_d;
  logic signed [CW-1:0]     num_q, num_d, den_q, den_d;
  logic signed [CW-1:0]     cx_q, cx_d, cy_q, cy_d;
  logic signed [ZW-1:0]     cz_q, cz_d;
  logic signed [PW-1:0]     fresh_q, fresh_d;
  logic signed [PW-1:0]     pitch_q, pitch_d;

  logic signed [QW-1:0]     op_a, op_b;
  mul_op_e                  acc_op;
  logic signed [CW-1:0]     prod_ext, den2, xs, ys;
  logic signed [ZW-1:0]     atan_v, ang, rnd;
  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0]        mag;
  logic signed [NEXT_W-1:0] nxt, step_s;
  logic                     out_free;

  assign in_ready_o    = (state_q == ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign pitch_angle_o = pitch_q;
  assign out_free      = !out_valid_q || out_ready_i;

  assign prod_ext = CW'(prod_q);
  assign den2     = den_q <<< 1;
  assign xs       = cx_q >>> iter_q;
  assign ys       = cy_q >>> iter_q;
  assign atan_v   = atan_q16(TAB_W'(iter_q));
  assign ang      = cz_q - HALF_PI_Q16;
  assign rnd      = (ang + RND_BIAS) >>> RND_SH;
  assign diff     = DIFF_W'(fresh_q) - DIFF_W'(held_q);
  assign mag      = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
  assign step_s   = $signed({{(NEXT_W-STEP_W){1'b0}}, step_q});
  assign nxt      = diff[DIFF_W-1] ? (NEXT_W'(held_q) - step_s) : (NEXT_W'(held_q) + step_s);
  assign acc_op   = mul_op_e'(mop_q - 3'd1);

  always_comb begin
    unique case (mop_q)
      MUL_WW:  begin op_a = qw_q; op_b = qw_q; end
      MUL_XX:  begin op_a = qx_q; op_b = qx_q; end
      MUL_YY:  begin op_a = qy_q; op_b = qy_q; end
      MUL_ZZ:  begin op_a = qz_q; op_b = qz_q; end
      MUL_YZ:  begin op_a = qy_q; op_b = qz_q; end
      MUL_WX:  begin op_a = qw_q; op_b = qx_q; end
      default: begin op_a = qw_q; op_b = qx_q; end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    mop_d       = mop_q;
    iter_d      = iter_q;
    thr_d       = thr_q;
    step_d      = step_q;
    held_d      = held_q;
    out_valid_d = out_valid_q && !out_ready_i;
    qw_d        = qw_q;
    qx_d        = qx_q;
    qy_d        = qy_q;
    qz_d        = qz_q;
    prod_d      = PRODW'(op_a) * PRODW'(op_b);
    num_d       = num_q;
    den_d       = den_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    cz_d        = cz_q;
    fresh_d     = fresh_q;
    pitch_d     = pitch_q;

    if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_JUMP_THRESHOLD: thr_d  = cfg_data_i[THR_W-1:0];
        REG_SLEW_STEP:      step_d = cfg_data_i[STEP_W-1:0];
        default:            ;
      endcase
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          qw_d    = quat_w_i;
          qx_d    = quat_x_i;
          qy_d    = quat_y_i;
          qz_d    = quat_z_i;
          num_d   = '0;
          den_d   = '0;
          mop_d   = MUL_WW;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        if (mop_q != MUL_WW) begin
          unique case (acc_op) inside
            MUL_WW, MUL_ZZ: num_d = num_q + prod_ext;
            MUL_XX, MUL_YY: num_d = num_q - prod_ext;
            MUL_YZ, MUL_WX: den_d = den_q + prod_ext;
            default:        ;
          endcase
        end
        if (mop_q == MUL_END) begin
          state_d = ST_PREP;
        end else begin
          mop_d = mul_op_e'(mop_q + 3'd1);
        end
      end
      ST_PREP: begin
        iter_d = '0;
        if (num_q == '0 && den_q == '0) begin
          cz_d    = '0;
          state_d = ST_ROUND;
        end else begin
          if (den2 < 0) begin
            cx_d = -den2;
            cy_d = -num_q;
            cz_d = (num_q >= 0) ? PI_Q16 : -PI_Q16;
          end else begin
            cx_d = den2;
            cy_d = num_q;
            cz_d = '0;
          end
          state_d = ST_ROT;
        end
      end
      ST_ROT: begin
        if (cy_q >= 0) begin
          cx_d = cx_q + ys;
          cy_d = cy_q - xs;
          cz_d = cz_q + atan_v;
        end else begin
          cx_d = cx_q - ys;
          cy_d = cy_q + xs;
          cz_d = cz_q - atan_v;
        end
        if (iter_q == IterLast) begin
          state_d = ST_ROUND;
        end else begin
          iter_d = iter_q + 1'b1;
        end
      end
      ST_ROUND: begin
        if (rnd < ZW'(PITCH_MIN)) begin
          fresh_d = PITCH_MIN;
        end else if (rnd > ZW'(PITCH_MAX)) begin
          fresh_d = PITCH_MAX;
        end else begin
          fresh_d = PW'(rnd);
        end
        state_d = ST_SLEW;
      end
      ST_SLEW: begin
        if (out_free) begin
          if (mag > DIFF_W'(thr_q)) begin
            if (nxt < NEXT_W'(PITCH_MIN)) begin
              held_d = PITCH_MIN;
            end else if (nxt > NEXT_W'(PITCH_MAX)) begin
              held_d = PITCH_MAX;
            end else begin
              held_d = PW'(nxt);
            end
          end else begin
            held_d = fresh_q;
          end
          pitch_d     = held_d;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mop_q       <= MUL_WW;
      iter_q      <= '0;
      thr_q       <= THR_RESET;
      step_q      <= STEP_RESET;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mop_q       <= mop_d;
      iter_q      <= iter_d;
      thr_q       <= thr_d;
      step_q      <= step_d;
      held_q      <= held_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    qw_q    <= qw_d;
    qx_q    <= qx_d;
    qy_q    <= qy_d;
    qz_q    <= qz_d;
    prod_q  <= prod_d;
    num_q   <= num_d;
    den_q   <= den_d;
    cx_q    <= cx_d;
    cy_q    <= cy_d;
    cz_q    <= cz_d;
    fresh_q <= fresh_d;
    pitch_q <= pitch_d;
  end

  a_iter_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ROT |-> iter_q <= IterLast)
    else $error("CORDIC iteration count out of range");

  a_held_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q >= PITCH_MIN && held_q <= PITCH_MAX)
    else $error("held pitch out of range");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == ST_MUL && mop_q == MUL_WW)
    else $error("accepted request did not start multiply phase");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == ST_SLEW)
    else $error("result raised outside slew cycle");

endmodule
`default_nettype wire
